@@ sv/hrb_pkg.sv @@
package hrb_pkg;

	// Number of entries in each ring.
	localparam int RING_SIZE = 19;
	localparam int IDX_W = $clog2(RING_SIZE);
	// Hot-spot positions arrive as 5-bit fields. Compares are done at the
	// wider of that width and the index width.
	localparam int SPOT_W = 5;
	localparam int CMP_W = (IDX_W > SPOT_W) ? IDX_W : SPOT_W;

	localparam int HEAT_W = 16;
	localparam int THR_W = 11;
	localparam int SPOT_PAIRS = 4;
	localparam int PAIR_W = $clog2(SPOT_PAIRS);

	localparam logic [HEAT_W-1:0] SPOT_MAX = HEAT_W'((1 << 14) - 1);

	// Cell operations.
	localparam logic [2:0] OP_HOLD  = 3'd0;
	localparam logic [2:0] OP_DECAY = 3'd1;
	localparam logic [2:0] OP_BLUR  = 3'd2;
	localparam logic [2:0] OP_SPOT  = 3'd3;
	localparam logic [2:0] OP_SHIFT = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [HEAT_W-1:0] back_gain;
		logic [HEAT_W-1:0] front_gain;
		logic [HEAT_W-1:0] back_add;
		logic [HEAT_W-1:0] front_add;
		logic [SPOT_W-1:0] back_spot;
		logic [SPOT_W-1:0] front_spot;
	} hrb_ctrl_t;

endpackage

@@ sv/heat_ring_blur_step.sv @@
// Two-ring heat simulation, one tick per input item.
// The slave channel (s_tvalid, s_tready, s_tdata) takes one tick item that
// carries the throttle and eight hot-spot positions. The master channel
// (m_tvalid, m_tready, m_tdata, m_tlast) then gives one item per ring index,
// index 0 first, with the front and back heat of that entry; m_tlast marks
// the item of the highest index.
// Each ring entry lives in its own cell. After an item is accepted the
// cells decay, then blur (every cell reads its two neighbors' registered
// values), then take the four hot-spot pairs in turn. The rings then
// rotate toward cell 0 by one entry per delivered item, so cell 0 always
// drives the result and after a full turn the rings are back in place.
// The sequencer runs one tick at a time and s_tready is high only while no
// tick is in progress, so a new tick is taken only after the last result
// of the current one has been delivered.
// A stall on the master side simply holds the rotation; nothing is lost.
// Reset clears both rings to zero and returns the sequencer to idle.
module heat_ring_blur_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, from bit 0: throttle[10:0], back_spot_a..d (5 bits each),
	// front_spot_a..d (5 bits each), zero fill to 56 bits.
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, from bit 0: position[4:0], front_heat[15:0], back_heat[15:0],
	// zero fill to 40 bits.
	output logic [39:0] m_tdata,
	output logic        m_tlast
);
	import hrb_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DECAY = 3'd1;
	localparam logic [2:0] ST_BLUR  = 3'd2;
	localparam logic [2:0] ST_SPOT  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]        state_q;
	logic [PAIR_W-1:0] pair_q;
	logic [IDX_W-1:0]  out_cnt_q;

	// Tick payload held for the whole run.
	logic [THR_W-1:0]  throttle_q;
	logic [SPOT_W-1:0] back_spot_q [SPOT_PAIRS];
	logic [SPOT_W-1:0] front_spot_q [SPOT_PAIRS];

	logic [HEAT_W-1:0] base;
	hrb_ctrl_t         ctrl;
	logic              in_fire, out_fire;
	logic [CMP_W-1:0]  pos_wide;

	logic [HEAT_W-1:0] cell_front [RING_SIZE];
	logic [HEAT_W-1:0] cell_back [RING_SIZE];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// Base heat is the throttle times eight.
	assign base = {2'b00, throttle_q, 3'b000};

	always_comb begin
		ctrl.op         = OP_HOLD;
		ctrl.back_gain  = {4'b0000, base[HEAT_W-1:4]};
		ctrl.front_gain = {6'b000000, base[HEAT_W-1:6]};
		ctrl.back_add   = {1'b0, base[HEAT_W-1:1]};
		ctrl.front_add  = {2'b00, base[HEAT_W-1:2]};
		ctrl.back_spot  = back_spot_q[pair_q];
		ctrl.front_spot = front_spot_q[pair_q];
		case (state_q)
			ST_DECAY: ctrl.op = OP_DECAY;
			ST_BLUR:  ctrl.op = OP_BLUR;
			ST_SPOT:  ctrl.op = OP_SPOT;
			ST_OUT:   ctrl.op = out_fire ? OP_SHIFT : OP_HOLD;
			default:  ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pair_q    <= '0;
			out_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DECAY;
					end
				end
				ST_DECAY: begin
					state_q <= ST_BLUR;
				end
				ST_BLUR: begin
					state_q <= ST_SPOT;
					pair_q  <= '0;
				end
				ST_SPOT: begin
					if (pair_q == PAIR_W'(SPOT_PAIRS - 1)) begin
						state_q   <= ST_OUT;
						out_cnt_q <= '0;
					end else begin
						pair_q <= pair_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						if (out_cnt_q == IDX_W'(RING_SIZE - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							out_cnt_q <= out_cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			throttle_q <= s_tdata[THR_W-1:0];
			for (int k = 0; k < SPOT_PAIRS; k++) begin
				back_spot_q[k]  <= s_tdata[THR_W + SPOT_W*k +: SPOT_W];
				front_spot_q[k] <= s_tdata[THR_W + SPOT_W*(SPOT_PAIRS + k) +: SPOT_W];
			end
		end
	end

	// The ring of cells; each one sees its left and right neighbor.
	for (genvar i = 0; i < RING_SIZE; i++) begin : g_cell
		localparam int L = (i == 0) ? RING_SIZE - 1 : i - 1;
		localparam int R = (i == RING_SIZE - 1) ? 0 : i + 1;
		hrb_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.my_idx      (CMP_W'(i)),
			.left_front  (cell_front[L]),
			.left_back   (cell_back[L]),
			.right_front (cell_front[R]),
			.right_back  (cell_back[R]),
			.front       (cell_front[i]),
			.back        (cell_back[i])
		);
	end

	// Cell 0 always holds the entry being reported.
	assign pos_wide = CMP_W'(out_cnt_q);
	assign m_tdata  = {3'b000, cell_back[0], cell_front[0], pos_wide[SPOT_W-1:0]};
	assign m_tlast  = (out_cnt_q == IDX_W'(RING_SIZE - 1));

`ifndef SYNTHESIS
	// No new tick is taken while results of the current one are pending.
	a_no_accept_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while results pending");

	// An accepted tick starts the processing run.
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (!s_tready && !m_tvalid))
		else $error("tick accepted but run did not start");

	// The last item of a run closes it.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("run did not end after last item");

	// Results of a run come without gaps until the last one.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !m_tlast) |=> m_tvalid)
		else $error("run stopped before last item");
`endif

endmodule

@@ sv/hrb_cell.sv @@
module hrb_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hrb_pkg::hrb_ctrl_t            ctrl,
	input  logic [hrb_pkg::CMP_W-1:0]     my_idx,
	input  logic [hrb_pkg::HEAT_W-1:0]    left_front,
	input  logic [hrb_pkg::HEAT_W-1:0]    left_back,
	input  logic [hrb_pkg::HEAT_W-1:0]    right_front,
	input  logic [hrb_pkg::HEAT_W-1:0]    right_back,
	output logic [hrb_pkg::HEAT_W-1:0]    front,
	output logic [hrb_pkg::HEAT_W-1:0]    back
);
	import hrb_pkg::*;

	logic [HEAT_W-1:0] front_q, back_q;
	logic [HEAT_W-1:0] front_d, back_d;
	logic [HEAT_W-1:0] att_f, att_b;
	logic [HEAT_W:0]   nsum_f, nsum_b;
	logic [HEAT_W-1:0] spot_f, spot_b;
	logic              hit_f, hit_b;

	always_comb begin
		// Blur terms: 7/8 of self and the neighbor sum at 17 bits.
		att_f  = front_q - {3'b000, front_q[HEAT_W-1:3]};
		att_b  = back_q - {3'b000, back_q[HEAT_W-1:3]};
		nsum_f = {1'b0, left_front} + {1'b0, right_front};
		nsum_b = {1'b0, left_back} + {1'b0, right_back};
		// Hot-spot add wraps first, then saturates.
		spot_f = front_q + ctrl.front_add;
		spot_b = back_q + ctrl.back_add;
		if (spot_f > SPOT_MAX) begin
			spot_f = SPOT_MAX;
		end
		if (spot_b > SPOT_MAX) begin
			spot_b = SPOT_MAX;
		end
		hit_f = (CMP_W'(ctrl.front_spot) == my_idx);
		hit_b = (CMP_W'(ctrl.back_spot) == my_idx);

		front_d = front_q;
		back_d  = back_q;
		case (ctrl.op)
			OP_DECAY: begin
				front_d = front_q - {4'b0000, front_q[HEAT_W-1:4]} + ctrl.front_gain;
				back_d  = back_q - {4'b0000, back_q[HEAT_W-1:4]} + ctrl.back_gain;
			end
			OP_BLUR: begin
				front_d = att_f + {4'b0000, nsum_f[HEAT_W:5]} + {4'b0000, att_b[HEAT_W-1:4]};
				back_d  = att_b + {4'b0000, nsum_b[HEAT_W:5]} + {4'b0000, att_f[HEAT_W-1:4]};
			end
			OP_SPOT: begin
				if (hit_f) begin
					front_d = spot_f;
				end
				if (hit_b) begin
					back_d = spot_b;
				end
			end
			OP_SHIFT: begin
				front_d = right_front;
				back_d  = right_back;
			end
			default: begin
				front_d = front_q;
				back_d  = back_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
		end else begin
			front_q <= front_d;
			back_q  <= back_d;
		end
	end

	assign front = front_q;
	assign back  = back_q;

endmodule
